// ===== sv/hofr_pkg.sv =====
// shared types, constants and byte/crc helper functions for the report framer
// used by hofr_front, hofr_queue, hofr_back and the top level
package hofr_pkg;

  // report byte constants
  localparam logic [7:0] WL_HEADER   = 8'h31;
  localparam logic [7:0] REPORT_ID   = 8'h02;
  localparam logic [7:0] FLAG_TRIG   = 8'h0F;
  localparam logic [7:0] FLAG_BASE   = 8'h03;
  localparam logic [7:0] EFFECT_CONT = 8'h01;
  localparam logic [7:0] RIGHT_START = 8'h40;
  localparam logic [7:0] LEFT_START  = 8'h30;

  // crc constants
  localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES      = 32'hFFFFFFFF;
  localparam logic [7:0]  CRC_SEED      = 8'hA2;
  localparam logic [15:0] CRC_SPAN      = 16'd74;
  localparam logic [15:0] CRC_POS       = 16'd74;
  localparam int          CRC_WORDS     = 19;
  localparam logic [4:0]  CRC_LAST_WORD = 5'(CRC_WORDS - 1);

  // common block offsets
  localparam logic [15:0] OFS_FLAG    = 16'd0;
  localparam logic [15:0] OFS_STRONG  = 16'd2;
  localparam logic [15:0] OFS_WEAK    = 16'd3;
  localparam logic [15:0] OFS_RIGHT   = 16'd10;
  localparam logic [15:0] OFS_LEFT    = 16'd21;

  // register map
  localparam logic [8:0] REPORT_LEN_RESET = 9'd78;
  localparam logic [1:0] REG_WIRELESS = 2'd0;
  localparam logic [1:0] REG_TRIGGERS = 2'd1;
  localparam logic [1:0] REG_LENGTH   = 2'd2;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] strong_motor;
    logic [7:0] weak_motor;
    logic [7:0] right_trigger_force;
    logic [7:0] left_trigger_force;
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] crc;
  } rec_t;

  // fold one byte into a reflected crc
  function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc_in,
                                                input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  localparam logic [31:0] CRC_INIT = crc_fold_byte(CRC_ONES, CRC_SEED);

  // one trigger effect byte, pos 0..2 within the effect
  function automatic logic [7:0] effect_byte(input logic [1:0] pos, input logic [7:0] force_lvl,
                                             input logic [7:0] start);
    logic [7:0] b;
    b = 8'h00;
    if (force_lvl != 8'h00) begin
      case (pos)
        2'd0:    b = EFFECT_CONT;
        2'd1:    b = start;
        2'd2:    b = force_lvl;
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

  // report image byte at address a
  function automatic logic [7:0] byte_at(input logic [15:0] a, input logic wl,
                                         input logic trig, input cmd_t c,
                                         input logic [31:0] crc);
    logic [15:0] rel;
    logic [15:0] crel;
    logic [7:0]  b;
    rel  = a - (wl ? 16'd2 : 16'd1);
    crel = a - CRC_POS;
    b    = 8'h00;
    if (a == 16'd0) begin
      b = wl ? WL_HEADER : REPORT_ID;
    end else if (wl && a == 16'd1) begin
      b = REPORT_ID;
    end else if (wl && a >= CRC_POS && a < CRC_POS + 16'd4) begin
      case (crel[1:0])
        2'd0:    b = crc[7:0];
        2'd1:    b = crc[15:8];
        2'd2:    b = crc[23:16];
        default: b = crc[31:24];
      endcase
    end else if (rel == OFS_FLAG) begin
      b = trig ? FLAG_TRIG : FLAG_BASE;
    end else if (rel == OFS_STRONG) begin
      b = c.strong_motor;
    end else if (rel == OFS_WEAK) begin
      b = c.weak_motor;
    end else if (trig && rel >= OFS_RIGHT && rel < OFS_RIGHT + 16'd3) begin
      b = effect_byte(2'(rel - OFS_RIGHT), c.right_trigger_force, RIGHT_START);
    end else if (trig && rel >= OFS_LEFT && rel < OFS_LEFT + 16'd3) begin
      b = effect_byte(2'(rel - OFS_LEFT), c.left_trigger_force, LEFT_START);
    end
    return b;
  endfunction

endpackage

// ===== sv/haptic_output_report_framer_top.sv =====
// top level of the report framer: config registers, front, queue and back
// depends on hofr_pkg, hofr_front, hofr_queue, hofr_back
//
// channel  | handshake          | payload
// ---------+--------------------+---------------------------------------------------
// command  | push / full        | strong_motor, weak_motor, right/left_trigger_force
// report   | pop / empty        | report_word, valid_bytes, last_word
// config   | psel/penable/pready| paddr (0,4,8), pwdata, prdata
//
// the back emits one word per cycle while the output is popped, ceil(report_length/4) words per command
// (20 for the 78-byte default); the front folds the crc words of a wireless command before
// its hand-off and hands a wired command on at once, so the back sets the rate for long reports
// a two-entry queue lets the front run the next crc while the back drains words
// the first word passes the front command register, the queue and the output register; rst is synchronous
module haptic_output_report_framer_top import hofr_pkg::*; #(
  parameter int MAX_REPORT_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  strong_motor,
  input  logic [7:0]  weak_motor,
  input  logic [7:0]  right_trigger_force,
  input  logic [7:0]  left_trigger_force,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] report_word,
  output logic [2:0]  valid_bytes,
  output logic        last_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       wireless_mode, triggers_enabled;
  logic [8:0] report_length;
  logic       cfg_wr;
  cmd_t       cmd_in;
  logic       q_push, q_full, q_pop, q_empty;
  rec_t       q_wdata, q_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wireless_mode    <= 1'b1;
      triggers_enabled <= 1'b0;
      report_length    <= REPORT_LEN_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WIRELESS: wireless_mode    <= pwdata[0];
        REG_TRIGGERS: triggers_enabled <= pwdata[0];
        REG_LENGTH:   report_length    <= pwdata[8:0];
        default:      ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      REG_WIRELESS: prdata = {31'h0, wireless_mode};
      REG_TRIGGERS: prdata = {31'h0, triggers_enabled};
      REG_LENGTH:   prdata = {23'h0, report_length};
      default:      prdata = 32'h0;
    endcase
  end

  assign cmd_in = '{strong_motor: strong_motor, weak_motor: weak_motor,
                    right_trigger_force: right_trigger_force,
                    left_trigger_force: left_trigger_force};

  hofr_front u_front (
    .clk              (clk),
    .rst              (rst),
    .wireless_mode    (wireless_mode),
    .triggers_enabled (triggers_enabled),
    .push             (push),
    .full             (full),
    .cmd_in           (cmd_in),
    .q_push           (q_push),
    .q_wdata          (q_wdata),
    .q_full           (q_full)
  );

  hofr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  hofr_back #(
    .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .wireless_mode    (wireless_mode),
    .triggers_enabled (triggers_enabled),
    .report_length    (report_length),
    .q_empty          (q_empty),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .report_word      (report_word),
    .valid_bytes      (valid_bytes),
    .last_word        (last_word)
  );

endmodule

// ===== sv/hofr_front.sv =====
// front part: accepts a command and, in wireless mode, runs the crc over bytes 0..73, one word a cycle
// depends on hofr_pkg
module hofr_front import hofr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wireless_mode,
  input  logic        triggers_enabled,
  input  logic        push,
  output logic        full,
  input  cmd_t        cmd_in,
  output logic        q_push,
  output rec_t        q_wdata,
  input  logic        q_full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CRC  = 3'b010,
    F_HOLD = 3'b100
  } front_state_t;

  front_state_t state, state_next;
  cmd_t         cmd;
  logic [31:0]  crc, crc_next;
  logic [4:0]   cnt;
  logic         accept;
  logic [15:0]  base;

  // handshake toward the queue and the input
  assign q_push  = (state == F_HOLD) && !q_full;
  assign full    = !((state == F_IDLE) || q_push);
  assign accept  = push && !full;
  assign q_wdata = '{cmd: cmd, crc: ~crc};
  assign base    = {9'h0, cnt, 2'b00};

  // fold the bytes of one word that lie inside the crc span
  always_comb begin
    crc_next = crc;
    for (int k = 0; k < 4; k++) begin
      if (base + 16'(k) < CRC_SPAN) begin
        crc_next = crc_fold_byte(crc_next,
                     byte_at(base + 16'(k), wireless_mode, triggers_enabled, cmd, 32'h0));
      end
    end
  end

  // state sequencing
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (accept) state_next = wireless_mode ? F_CRC : F_HOLD;
      F_CRC:   if (cnt == CRC_LAST_WORD) state_next = F_HOLD;
      F_HOLD: begin
        if (accept) state_next = wireless_mode ? F_CRC : F_HOLD;
        else if (q_push) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // payload and crc accumulator
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_in;
      crc <= CRC_INIT;
      cnt <= 5'd0;
    end else if (state == F_CRC) begin
      crc <= crc_next;
      cnt <= cnt + 5'd1;
    end
  end

endmodule

// ===== sv/hofr_queue.sv =====
// short register queue of built records between front and back
// depends on hofr_pkg
module hofr_queue import hofr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t wdata,
  output logic full,
  input  logic pop,
  output logic empty,
  output rec_t rdata
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  rec_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + PW'(1);
      if (pop)  rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

endmodule

// ===== sv/hofr_back.sv =====
// back part: serializes one record into report words with an output register
// depends on hofr_pkg
module hofr_back import hofr_pkg::*; #(
  parameter int MAX_REPORT_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wireless_mode,
  input  logic        triggers_enabled,
  input  logic [8:0]  report_length,
  input  logic        q_empty,
  input  rec_t        q_rdata,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] report_word,
  output logic [2:0]  valid_bytes,
  output logic        last_word
);

  localparam int LEN_W = $clog2(MAX_REPORT_BYTES + 1);
  localparam int WW    = $clog2((MAX_REPORT_BYTES + 3) / 4);

  logic             out_valid;
  logic [WW-1:0]    widx;
  logic [LEN_W-1:0] len;
  logic [15:0]      base, rem;
  logic             load, is_last;
  logic [2:0]       vb;
  logic [31:0]      word;

  // saturated report length, zero counts as one byte
  always_comb begin
    if (32'(report_length) > 32'(MAX_REPORT_BYTES)) len = LEN_W'(MAX_REPORT_BYTES);
    else if (report_length == 9'd0) len = LEN_W'(1);
    else len = LEN_W'(report_length);
  end

  // word position, valid byte count and content
  assign base    = 16'({widx, 2'b00});
  assign rem     = 16'(len) - base;
  assign is_last = (rem <= 16'd4);
  assign vb      = is_last ? rem[2:0] : 3'd4;

  always_comb begin
    word = 32'h0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < vb) begin
        word[8*k +: 8] = byte_at(base + 16'(k), wireless_mode, triggers_enabled,
                                 q_rdata.cmd, q_rdata.crc);
      end
    end
  end

  assign load  = !q_empty && (!out_valid || pop);
  assign q_pop = load && is_last;
  assign empty = !out_valid;

  // control: output valid and word index
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      widx      <= '0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (load) widx <= is_last ? '0 : widx + WW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      report_word <= word;
      valid_bytes <= vb;
      last_word   <= is_last;
    end
  end

endmodule
